// File: hdl/smeu_pkg.sv
package smeu_pkg;

   localparam int STACK_DEPTH = 256;
   localparam int DATA_W      = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = 9;
   localparam int STEP_W      = $clog2(DATA_W);

   localparam logic [3:0] CMD_PUSH = 4'd0;
   localparam logic [3:0] CMD_POP  = 4'd1;
   localparam logic [3:0] CMD_SWAP = 4'd2;
   localparam logic [3:0] CMD_ADD  = 4'd3;
   localparam logic [3:0] CMD_MUL  = 4'd4;
   localparam logic [3:0] CMD_SUB  = 4'd5;
   localparam logic [3:0] CMD_DIV  = 4'd6;
   localparam logic [3:0] CMD_MOD  = 4'd7;
   localparam logic [3:0] CMD_DUP  = 4'd8;
   localparam logic [3:0] CMD_DUP2 = 4'd9;
   localparam logic [3:0] CMD_TOP  = 4'd10;
   localparam logic [3:0] CMD_JEQ0 = 4'd11;
   localparam logic [3:0] CMD_JGT0 = 4'd12;
   localparam logic [3:0] CMD_JLT0 = 4'd13;
   localparam logic [3:0] CMD_JUMP = 4'd14;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_DIV0    = 3'd1;
   localparam logic [2:0] ERR_UNDER   = 3'd2;
   localparam logic [2:0] ERR_OVER    = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN = 3'd4;

   // datapath step codes issued by the controller
   localparam logic [2:0] STEP_NONE    = 3'd0;
   localparam logic [2:0] STEP_EXEC    = 3'd1;
   localparam logic [2:0] STEP_FILL    = 3'd2;
   localparam logic [2:0] STEP_POP2    = 3'd3;
   localparam logic [2:0] STEP_WR2     = 3'd4;
   localparam logic [2:0] STEP_DIVDONE = 3'd5;
   localparam logic [2:0] STEP_RESP    = 3'd6;

   typedef struct packed {
      logic       load;
      logic [2:0] step;
      logic       div_start;
   } ctrl_type;

   typedef struct packed {
      logic [3:0] cmd;
      logic [2:0] err;
      logic       div_done;
      logic       out_free;
   } stat_type;

endpackage

// File: hdl/stack_machine_execute_unit_core.sv
// Stack machine execute unit: runs one decoded instruction per transaction
// on a 256-entry operand stack of 32-bit words.
// Request channel (req_valid/req_ready): req_command and req_operand.
// Response channel (rsp_valid/rsp_ready): one response per request carrying
// the top of stack, the top report strobe, the branch decision, an error
// code and the stack depth after the instruction.
// Path from request acceptance to the edge that raises rsp_valid: push, swap,
// dup, top, jumps and errors go straight to the response; pop, add, sub and
// mul add one read of the stack RAM to refill the second-of-stack register,
// dup2 a second RAM write; divide by zero pops both operands with a refill
// after each; div and mod wait on the radix-2 divider that resolves one
// quotient bit a cycle (32 steps plus the start and finish).
// One transaction is in flight at a time; a new request is taken in the cycle
// after the previous response is loaded.
// The response register frees the core: a finished response may wait on a
// stalled receiver while the next request is already being executed; the
// core only holds when its next response finds the register still full.
// Reset (synchronous, active high) empties the stack and drops any
// pending response; stack RAM contents are not cleared.
module stack_machine_execute_unit_core
   import smeu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_command,
   input  logic signed [31:0] req_operand,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_top_value,
   output logic               rsp_report_valid,
   output logic               rsp_branch_taken,
   output logic [2:0]         rsp_error_code,
   output logic [8:0]         rsp_depth
);

   ctrl_type ctrl;
   stat_type stat;

   // sequencing: accept, execute, RAM refill, second pop, second write, divide wait, response load
   smeu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // top two entries live in registers, the rest in the stack RAM
   smeu_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_command      (req_command),
      .req_operand      (req_operand),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_top_value    (rsp_top_value),
      .rsp_report_valid (rsp_report_valid),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_error_code   (rsp_error_code),
      .rsp_depth        (rsp_depth)
   );

endmodule

// File: hdl/smeu_div.sv
module smeu_div
   import smeu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              is_mod,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] result
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              negq_ff, negq_in;
   logic              negr_ff, negr_in;
   logic              mod_ff, mod_in;
   logic [DATA_W:0]   trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      negq_in = negq_ff;
      negr_in = negr_ff;
      mod_in  = mod_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         negq_in = dividend[DATA_W-1] ^ divisor[DATA_W-1];
         negr_in = dividend[DATA_W-1];
         mod_in  = is_mod;
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      mod_ff  <= mod_in;
   end

   assign done   = done_ff;
   assign result = mod_ff ? (negr_ff ? (~rem_ff + 1'b1) : rem_ff)
                          : (negq_ff ? (~quo_ff + 1'b1) : quo_ff);

endmodule

// File: hdl/smeu_datapath.sv
module smeu_datapath
   import smeu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   output stat_type            stat,
   input  logic [3:0]          req_command,
   input  logic signed [31:0]  req_operand,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_top_value,
   output logic                rsp_report_valid,
   output logic                rsp_branch_taken,
   output logic [2:0]          rsp_error_code,
   output logic [DEPTH_W-1:0]  rsp_depth
);

   logic [DATA_W-1:0] mem [STACK_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   logic [3:0]        cmd_ff, cmd_in;
   logic [DATA_W-1:0] opnd_ff, opnd_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [DATA_W-1:0] nos_ff, nos_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [2:0]        err_ff, err_in;
   logic              report_ff, report_in;
   logic              taken_ff, taken_in;

   logic              ovalid_ff, ovalid_in;
   logic [DATA_W-1:0] otop_ff, otop_in;
   logic              orep_ff, orep_in;
   logic              otak_ff, otak_in;
   logic [2:0]        oerr_ff, oerr_in;
   logic [DEPTH_W-1:0] odep_ff, odep_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [DATA_W-1:0] mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;

   logic [1:0]        need;
   logic [1:0]        grow;
   logic              known;
   logic [2:0]        err_calc;
   logic [DATA_W-1:0] alu;
   logic [DATA_W-1:0] prod;
   logic              div_done;
   logic [DATA_W-1:0] div_result;

   smeu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .is_mod   (cmd_ff == CMD_MOD),
      .dividend (nos_ff),
      .divisor  (tos_ff),
      .done     (div_done),
      .result   (div_result)
   );

   always_comb begin
      need  = 2'd0;
      grow  = 2'd0;
      known = 1'b1;
      case (cmd_ff)
         CMD_PUSH: grow = 2'd1;
         CMD_POP, CMD_TOP, CMD_JEQ0, CMD_JGT0, CMD_JLT0: need = 2'd1;
         CMD_SWAP, CMD_ADD, CMD_MUL, CMD_SUB, CMD_DIV, CMD_MOD: need = 2'd2;
         CMD_DUP: begin
            need = 2'd1;
            grow = 2'd1;
         end
         CMD_DUP2: begin
            need = 2'd2;
            grow = 2'd2;
         end
         CMD_JUMP: known = 1'b1;
         default: known = 1'b0;
      endcase
      if (!known)
         err_calc = ERR_UNKNOWN;
      else if (count_ff < CNT_W'(need))
         err_calc = ERR_UNDER;
      else if ({1'b0, count_ff} + (CNT_W+1)'(grow) > (CNT_W+1)'(STACK_DEPTH))
         err_calc = ERR_OVER;
      else if ((cmd_ff == CMD_DIV || cmd_ff == CMD_MOD) && tos_ff == '0)
         err_calc = ERR_DIV0;
      else
         err_calc = ERR_OK;
   end

   assign prod = nos_ff * tos_ff;

   always_comb begin
      case (cmd_ff)
         CMD_ADD: alu = nos_ff + tos_ff;
         CMD_SUB: alu = nos_ff - tos_ff;
         default: alu = prod;
      endcase
   end

   // read port follows the third entry from the top
   assign mem_raddr = ADDR_W'(count_ff - CNT_W'(3));

   always_comb begin
      cmd_in    = cmd_ff;
      opnd_in   = opnd_ff;
      tos_in    = tos_ff;
      nos_in    = nos_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      report_in = report_ff;
      taken_in  = taken_ff;
      mem_we    = 1'b0;
      mem_waddr = ADDR_W'(count_ff - CNT_W'(2));
      mem_wdata = nos_ff;
      ovalid_in = ovalid_ff && !rsp_ready;
      otop_in   = otop_ff;
      orep_in   = orep_ff;
      otak_in   = otak_ff;
      oerr_in   = oerr_ff;
      odep_in   = odep_ff;
      if (ctrl.load) begin
         cmd_in  = req_command;
         opnd_in = req_operand;
      end
      case (ctrl.step)
         STEP_EXEC: begin
            err_in    = err_calc;
            report_in = 1'b0;
            taken_in  = 1'b0;
            if (err_calc == ERR_DIV0) begin
               tos_in   = nos_ff;
               count_in = count_ff - 1'b1;
            end else if (err_calc == ERR_OK) begin
               case (cmd_ff)
                  CMD_PUSH: begin
                     mem_we   = (count_ff >= CNT_W'(2));
                     nos_in   = tos_ff;
                     tos_in   = opnd_ff;
                     count_in = count_ff + 1'b1;
                  end
                  CMD_POP: begin
                     tos_in   = nos_ff;
                     count_in = count_ff - 1'b1;
                  end
                  CMD_SWAP: begin
                     tos_in = nos_ff;
                     nos_in = tos_ff;
                  end
                  CMD_ADD, CMD_SUB, CMD_MUL: begin
                     tos_in   = alu;
                     count_in = count_ff - 1'b1;
                  end
                  CMD_DUP: begin
                     mem_we   = (count_ff >= CNT_W'(2));
                     nos_in   = tos_ff;
                     count_in = count_ff + 1'b1;
                  end
                  CMD_DUP2: mem_we = 1'b1;
                  CMD_TOP:  report_in = 1'b1;
                  CMD_JEQ0: taken_in = (tos_ff == '0);
                  CMD_JGT0: taken_in = ($signed(tos_ff) > 0);
                  CMD_JLT0: taken_in = tos_ff[DATA_W-1];
                  CMD_JUMP: taken_in = 1'b1;
                  default: taken_in = 1'b0;
               endcase
            end
         end
         STEP_FILL: nos_in = rdata_ff;
         STEP_POP2: begin
            tos_in   = nos_ff;
            count_in = count_ff - 1'b1;
         end
         STEP_WR2: begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(count_ff - 1'b1);
            mem_wdata = tos_ff;
            count_in  = count_ff + CNT_W'(2);
         end
         STEP_DIVDONE: begin
            tos_in   = div_result;
            count_in = count_ff - 1'b1;
         end
         STEP_RESP: begin
            ovalid_in = 1'b1;
            otop_in   = (count_ff != '0) ? tos_ff : '0;
            orep_in   = report_ff;
            otak_in   = taken_ff;
            oerr_in   = err_ff;
            odep_in   = DEPTH_W'(count_ff);
         end
         default: ovalid_in = ovalid_ff && !rsp_ready;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
      cmd_ff    <= cmd_in;
      opnd_ff   <= opnd_in;
      tos_ff    <= tos_in;
      nos_ff    <= nos_in;
      err_ff    <= err_in;
      report_ff <= report_in;
      taken_ff  <= taken_in;
      otop_ff   <= otop_in;
      orep_ff   <= orep_in;
      otak_ff   <= otak_in;
      oerr_ff   <= oerr_in;
      odep_ff   <= odep_in;
   end

   assign stat.cmd      = cmd_ff;
   assign stat.err      = err_calc;
   assign stat.div_done = div_done;
   assign stat.out_free = !ovalid_ff || rsp_ready;

   assign rsp_valid        = ovalid_ff;
   assign rsp_top_value    = otop_ff;
   assign rsp_report_valid = orep_ff;
   assign rsp_branch_taken = otak_ff;
   assign rsp_error_code   = oerr_ff;
   assign rsp_depth        = odep_ff;

endmodule

// File: hdl/smeu_ctrl.sv
module smeu_ctrl
   import smeu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctrl_type ctrl
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_POP2 = 3'd3;
   localparam logic [2:0] S_WR2  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;

   always_comb begin
      state_in       = state_ff;
      pend_in        = pend_ff;
      ctrl.load      = 1'b0;
      ctrl.step      = STEP_NONE;
      ctrl.div_start = 1'b0;
      req_ready      = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            ctrl.step = STEP_EXEC;
            pend_in   = 1'b0;
            if (stat.err == ERR_DIV0) begin
               pend_in  = 1'b1;
               state_in = S_FILL;
            end else if (stat.err != ERR_OK) begin
               state_in = S_DONE;
            end else begin
               case (stat.cmd)
                  CMD_POP, CMD_ADD, CMD_SUB, CMD_MUL: state_in = S_FILL;
                  CMD_DIV, CMD_MOD: begin
                     ctrl.div_start = 1'b1;
                     state_in       = S_DIV;
                  end
                  CMD_DUP2: state_in = S_WR2;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_FILL: begin
            ctrl.step = STEP_FILL;
            pend_in   = 1'b0;
            state_in  = pend_ff ? S_POP2 : S_DONE;
         end
         S_POP2: begin
            ctrl.step = STEP_POP2;
            state_in  = S_FILL;
         end
         S_WR2: begin
            ctrl.step = STEP_WR2;
            state_in  = S_DONE;
         end
         S_DIV: begin
            if (stat.div_done) begin
               ctrl.step = STEP_DIVDONE;
               state_in  = S_FILL;
            end
         end
         S_DONE: begin
            if (stat.out_free) begin
               ctrl.step = STEP_RESP;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// File: hdl/smeu_checker.sv
module smeu_checker
   import smeu_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_top_value,
   input logic               rsp_report_valid,
   input logic               rsp_branch_taken,
   input logic [2:0]         rsp_error_code,
   input logic [8:0]         rsp_depth
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth == 9'd0 |-> rsp_top_value == 32'sd0)
      else $error("empty stack reports nonzero top");

   a_err_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_OK |-> !rsp_report_valid && !rsp_branch_taken)
      else $error("failed instruction raised report or branch");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_report_valid && rsp_branch_taken))
      else $error("report and branch both set");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_depth <= 9'(STACK_DEPTH))
      else $error("depth beyond stack size");

endmodule

bind stack_machine_execute_unit_core smeu_checker u_smeu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_top_value    (rsp_top_value),
   .rsp_report_valid (rsp_report_valid),
   .rsp_branch_taken (rsp_branch_taken),
   .rsp_error_code   (rsp_error_code),
   .rsp_depth        (rsp_depth)
);

// File: dv/testbench.sv
module testbench;
   import smeu_pkg::*;

   localparam logic [3:0] CMD_UNKNOWN = 4'd15;

   // Snapshot of one response, as predicted or as observed on the port.
   typedef struct {
      logic signed [31:0] top_value;
      logic               report_valid;
      logic               branch_taken;
      logic [2:0]         error_code;
      logic [8:0]         depth;
   } stack_result_type;

   // Scoreboard: keeps a private copy of the operand stack, works out the
   // response of every accepted instruction and checks responses in order.
   class stack_scoreboard;
      logic [31:0]      stack_mem[STACK_DEPTH];
      int               count;
      stack_result_type pending_q[$];
      int               fail_count;

      function void clear();
         count = 0;
         pending_q.delete();
         fail_count = 0;
      endfunction

      function logic [31:0] peek(int below_top);
         return stack_mem[count - 1 - below_top];
      endfunction

      // Note an accepted instruction and queue its predicted response.
      function void note_request(logic [3:0] cmd, logic [31:0] opnd);
         stack_result_type   res;
         int                 need;
         int                 grow;
         logic [31:0]        a;
         logic [31:0]        b;
         logic [31:0]        r;
         logic signed [31:0] sa;
         logic signed [31:0] sb;
         res = '{default: '0};
         need = 0;
         grow = 0;
         a = '0;
         b = '0;
         case (cmd)
            CMD_PUSH: grow = 1;
            CMD_POP, CMD_TOP, CMD_JEQ0, CMD_JGT0, CMD_JLT0: need = 1;
            CMD_SWAP, CMD_ADD, CMD_MUL, CMD_SUB, CMD_DIV, CMD_MOD: need = 2;
            CMD_DUP: begin
               need = 1;
               grow = 1;
            end
            CMD_DUP2: begin
               need = 2;
               grow = 2;
            end
            CMD_JUMP: ;
            default: res.error_code = ERR_UNKNOWN;
         endcase
         if (res.error_code == ERR_OK && count < need)
            res.error_code = ERR_UNDER;
         else if (res.error_code == ERR_OK && count + grow > STACK_DEPTH)
            res.error_code = ERR_OVER;
         if (res.error_code == ERR_OK) begin
            if (need >= 1) a = peek(0);
            if (need >= 2) b = peek(1);
            sa = a;
            sb = b;
            case (cmd)
               CMD_PUSH: begin
                  stack_mem[count] = opnd;
                  count++;
               end
               CMD_POP: count--;
               CMD_SWAP: begin
                  stack_mem[count - 1] = b;
                  stack_mem[count - 2] = a;
               end
               CMD_ADD, CMD_MUL, CMD_SUB, CMD_DIV, CMD_MOD: begin
                  count -= 2;
                  if ((cmd == CMD_DIV || cmd == CMD_MOD) && a == 0)
                     res.error_code = ERR_DIV0;
                  else begin
                     case (cmd)
                        CMD_ADD: r = b + a;
                        CMD_MUL: r = b * a;
                        CMD_SUB: r = b - a;
                        // most negative / -1 wraps, and its remainder is 0
                        CMD_DIV: r = (sa == -1) ? -sb : sb / sa;
                        default: r = (sa == -1) ? 32'sd0 : sb % sa;
                     endcase
                     stack_mem[count] = r;
                     count++;
                  end
               end
               CMD_DUP: begin
                  stack_mem[count] = a;
                  count++;
               end
               CMD_DUP2: begin
                  stack_mem[count] = b;
                  stack_mem[count + 1] = a;
                  count += 2;
               end
               CMD_TOP: res.report_valid = 1'b1;
               CMD_JEQ0: res.branch_taken = (a == 0);
               CMD_JGT0: res.branch_taken = (sa > 0);
               CMD_JLT0: res.branch_taken = (sa < 0);
               CMD_JUMP: res.branch_taken = 1'b1;
               default: ;
            endcase
         end
         res.top_value = (count > 0) ? peek(0) : 32'd0;
         res.depth = count[8:0];
         pending_q.push_back(res);
      endfunction

      // Compare one accepted response against the oldest prediction.
      function void check_response(stack_result_type got);
         stack_result_type want;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response top=%0d depth=%0d", $time,
                     got.top_value, got.depth);
            fail_count++;
            return;
         end
         want = pending_q.pop_front();
         if (got.top_value !== want.top_value) begin
            $display("%0t: top_value expected %0d actual %0d", $time,
                     want.top_value, got.top_value);
            fail_count++;
         end
         if (got.report_valid !== want.report_valid) begin
            $display("%0t: report_valid expected %0b actual %0b", $time,
                     want.report_valid, got.report_valid);
            fail_count++;
         end
         if (got.branch_taken !== want.branch_taken) begin
            $display("%0t: branch_taken expected %0b actual %0b", $time,
                     want.branch_taken, got.branch_taken);
            fail_count++;
         end
         if (got.error_code !== want.error_code) begin
            $display("%0t: error_code expected %0d actual %0d", $time,
                     want.error_code, got.error_code);
            fail_count++;
         end
         if (got.depth !== want.depth) begin
            $display("%0t: depth expected %0d actual %0d", $time,
                     want.depth, got.depth);
            fail_count++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [3:0]         req_command;
   logic signed [31:0] req_operand;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [31:0] rsp_top_value;
   logic               rsp_report_valid;
   logic               rsp_branch_taken;
   logic [2:0]         rsp_error_code;
   logic [8:0]         rsp_depth;

   stack_scoreboard stack_sb;
   bit              hold_off_now;
   int              model_depth;

   stack_machine_execute_unit_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_operand     (req_operand),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_top_value   (rsp_top_value),
      .rsp_report_valid(rsp_report_valid),
      .rsp_branch_taken(rsp_branch_taken),
      .rsp_error_code  (rsp_error_code),
      .rsp_depth       (rsp_depth)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Offer one instruction and hold it until it is accepted.
   // The scoreboard sees it in the same step it is accepted.
   task automatic send_instr(logic [3:0] cmd, logic [31:0] opnd);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_operand <= opnd;
      do @(posedge clock); while (!req_ready);
      stack_sb.note_request(cmd, opnd);
      model_depth = stack_sb.count;
   endtask

   // Drop the request and wait until every predicted response is checked.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (stack_sb.pending_q.size() != 0);
   endtask

   // Pick a random value that lands on edge cases fairly often.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'd0;
         4: return $urandom_range(0, 20) - 10;
         default: return $urandom();
      endcase
   endfunction

   // Pick a command, biased toward the legal ones that keep the stack
   // well populated so that arithmetic rarely underflows.
   function automatic logic [3:0] pick_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (model_depth < 2 && roll < 60) return CMD_PUSH;
      if (model_depth > STACK_DEPTH - 3 && roll < 60) return CMD_POP;
      if (roll < 2) return CMD_UNKNOWN;
      return 4'($urandom_range(0, 14));
   endfunction

   // Check every accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            stack_sb.check_response('{rsp_top_value, rsp_report_valid,
                                      rsp_branch_taken, rsp_error_code,
                                      rsp_depth});
      end
   end

   // Receiver: random stalls, plus one long hold-off so the core backs up.
   initial begin
      int stall;
      rsp_ready    = 1'b0;
      hold_off_now = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off_now) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off_now = 1'b0;
         end
         stall = $urandom_range(0, 10);
         if ($urandom_range(0, 2) == 0) stall = 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      stack_sb      = new();
      stack_sb.clear();
      model_depth   = 0;
      req_valid     = 1'b0;
      req_command   = CMD_PUSH;
      req_operand   = '0;
      reset         = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: underflow on an empty stack, then every operation,
      // division by zero, the overflowing divide and unknown command.
      send_instr(CMD_POP, 32'd0);
      send_instr(CMD_TOP, 32'd0);
      send_instr(CMD_JEQ0, 32'd0);
      send_instr(CMD_JUMP, 32'd0);
      send_instr(CMD_UNKNOWN, 32'hffff_ffff);
      send_instr(CMD_PUSH, 32'h8000_0000);
      send_instr(CMD_PUSH, 32'hffff_ffff);
      send_instr(CMD_DUP2, 32'd0);
      send_instr(CMD_DIV, 32'd0);
      send_instr(CMD_JLT0, 32'd0);
      send_instr(CMD_MOD, 32'd0);
      send_instr(CMD_PUSH, 32'h7fff_ffff);
      send_instr(CMD_JGT0, 32'd0);
      send_instr(CMD_DUP, 32'd0);
      send_instr(CMD_ADD, 32'd0);
      send_instr(CMD_PUSH, 32'd0);
      send_instr(CMD_JEQ0, 32'd0);
      send_instr(CMD_DIV, 32'd0);
      send_instr(CMD_PUSH, 32'd7);
      send_instr(CMD_PUSH, 32'hffff_fffd);
      send_instr(CMD_SWAP, 32'd0);
      send_instr(CMD_MOD, 32'd0);
      send_instr(CMD_MUL, 32'd0);
      send_instr(CMD_SUB, 32'd0);
      send_instr(CMD_TOP, 32'd0);

      // Fill the stack to the top and force overflow on push, dup, dup2.
      while (model_depth < STACK_DEPTH) send_instr(CMD_PUSH, $urandom());
      send_instr(CMD_PUSH, 32'd1);
      send_instr(CMD_DUP, 32'd0);
      send_instr(CMD_DUP2, 32'd0);
      // Back down to a working depth.
      while (model_depth > 8) send_instr(CMD_POP, 32'd0);

      // Pause the sender until everything has come back.
      drain_responses();

      for (int i = 0; i < 520; i++) begin
         if (i == 150) hold_off_now = 1'b1;
         send_instr(pick_command(), pick_value());
      end

      drain_responses();
      repeat (100) @(posedge clock);
      if (stack_sb.fail_count == 0)
         $display("PASS stack_machine_execute_unit_core");
      else
         $display("FAIL stack_machine_execute_unit_core");
      $finish;
   end

   // Watchdog: fails the run if it does not finish in time.
   initial begin
      #800000;
      $display("FAIL stack_machine_execute_unit_core");
      $finish;
   end

endmodule
